@@ hw/rtl/pmfp_pkg.sv @@
// Shared types and constants for the pulse meter with filter and period.
// Used by every module of the block; has no dependencies of its own.
package pmfp_pkg;

  localparam int DATA_W      = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 2;

  // input opcodes
  localparam logic OP_PIN  = 1'b0;
  localparam logic OP_POLL = 1'b1;

  // filter modes
  localparam logic FILTER_SPACING = 1'b0;
  localparam logic FILTER_LEVEL   = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_TIME  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TIME = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD   = 2'd3;

  // configuration reset values
  localparam logic [DATA_W-1:0] RST_FILTER_TIME  = 32'd13;
  localparam logic [DATA_W-1:0] RST_TIMEOUT_TIME = 32'd300000000;
  localparam logic [DATA_W-1:0] RST_MAX_PERIOD   = 32'd0;

  typedef struct packed {
    logic              opcode;
    logic              pin_level;
    logic [DATA_W-1:0] now_us;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] pulse_count;
    logic [DATA_W-1:0] period_us;
    logic              flow_valid;
    logic              flow_zero;
    logic [DATA_W-1:0] total_pulses;
  } out_item_t;

  typedef struct packed {
    logic              filter_mode;
    logic [DATA_W-1:0] filter_time;
    logic [DATA_W-1:0] timeout_time;
    logic [DATA_W-1:0] max_period;
  } cfg_t;

  // one poll result waiting for its period division
  typedef struct packed {
    logic [DATA_W-1:0] num;
    logic [DATA_W-1:0] cnt;
    logic              flow_valid;
    logic              flow_zero;
    logic [DATA_W-1:0] total;
  } job_t;

endpackage

@@ hw/rtl/pmfp_front.sv @@
// Front end: accepts pin events and polls, runs the deglitch filters and the
// per-poll accounting, and hands division jobs to the queue. Uses pmfp_pkg.
module pmfp_front
  import pmfp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  cfg_t     cfg,
  output logic     job_valid,
  input  logic     job_ready,
  output job_t     job
);

  typedef enum logic [1:0] {F_IDLE, F_ACCT, F_PUSH} fstate_t;
  typedef enum logic [1:0] {M_INITIAL, M_RUNNING, M_TIMED_OUT} meter_t;

  fstate_t           state_r;
  meter_t            mode_r;
  logic [DATA_W-1:0] last_sent_r, last_det_r, last_rise_r, pending_r;
  logic [DATA_W-1:0] last_evt_r, lpe_r, total_r;
  logic              last_pin_r, latched_r, peek_r;
  logic [DATA_W-1:0] poll_now_r, cnt_r, det_r;

  // pin update
  logic              in_acc, is_poll, do_rise, do_level;
  logic [DATA_W-1:0] since_sent, since_evt;
  logic [DATA_W-1:0] sent_u, det_u, rise_u, pending_u, evt_u;
  logic              pin_u, latched_u;

  // poll accounting
  logic              dec, peek_mid, inc;
  logic [DATA_W-1:0] since_rise, cnt_a;
  logic              cnt_nz, timeout_hit;
  logic [DATA_W-1:0] total_sum, elapsed;

  assign in_ready  = (state_r == F_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign is_poll   = (in_data.opcode == OP_POLL);
  assign job_valid = (state_r == F_PUSH);

  always_comb begin
    do_rise  = 1'b0;
    do_level = 1'b0;
    if (is_poll) begin
      do_rise  = (cfg.filter_mode == FILTER_SPACING) && in_data.pin_level && !last_pin_r;
      do_level = (cfg.filter_mode == FILTER_LEVEL) && (in_data.pin_level != last_pin_r);
    end else begin
      do_rise  = (cfg.filter_mode == FILTER_SPACING) && in_data.pin_level;
      do_level = (cfg.filter_mode == FILTER_LEVEL);
    end
  end

  always_comb begin
    since_sent = in_data.now_us - last_sent_r;
    since_evt  = in_data.now_us - last_evt_r;
    sent_u     = last_sent_r;
    det_u      = last_det_r;
    rise_u     = last_rise_r;
    pending_u  = pending_r;
    evt_u      = last_evt_r;
    pin_u      = last_pin_r;
    latched_u  = latched_r;
    if (do_rise) begin
      if (since_sent >= cfg.filter_time) begin
        sent_u    = in_data.now_us;
        det_u     = in_data.now_us;
        rise_u    = in_data.now_us;
        pending_u = pending_r + 1'b1;
      end
      pin_u = 1'b1;
    end else if (do_level) begin
      if ((since_evt >= cfg.filter_time) && latched_r && !last_pin_r) begin
        latched_u = 1'b0;
      end else if ((since_evt >= cfg.filter_time) && !latched_r && last_pin_r) begin
        latched_u = 1'b1;
        det_u     = last_evt_r;
        pending_u = pending_r + 1'b1;
      end
      rise_u = (!latched_u && in_data.pin_level) ? in_data.now_us : det_u;
      evt_u  = in_data.now_us;
      pin_u  = in_data.pin_level;
    end
    // a poll always takes the sampled level, even when it was not a change
    if (is_poll) begin
      pin_u = in_data.pin_level;
    end
  end

  // repay an owed early count, then maybe count a stable pending edge early
  always_comb begin
    dec        = peek_r && (pending_r != '0);
    peek_mid   = peek_r && !dec;
    since_rise = poll_now_r - last_rise_r;
    inc        = !peek_mid && (last_rise_r != last_det_r) && (since_rise >= cfg.filter_time);
    cnt_a      = pending_r;
    if (inc && !dec) begin
      cnt_a = pending_r + 1'b1;
    end else if (dec && !inc) begin
      cnt_a = pending_r - 1'b1;
    end
  end

  always_comb begin
    cnt_nz         = (cnt_r != '0);
    total_sum      = total_r + cnt_r;
    elapsed        = poll_now_r - lpe_r;
    timeout_hit    = !cnt_nz && (mode_r != M_TIMED_OUT) && (elapsed > cfg.timeout_time);
    job.num        = det_r - lpe_r;
    job.cnt        = cnt_r;
    job.flow_valid = cnt_nz && (mode_r == M_RUNNING);
    job.flow_zero  = timeout_hit;
    job.total      = cnt_nz ? total_sum : total_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_IDLE;
      mode_r      <= M_INITIAL;
      last_sent_r <= '0;
      last_det_r  <= '0;
      last_rise_r <= '0;
      pending_r   <= '0;
      last_evt_r  <= '0;
      lpe_r       <= '0;
      total_r     <= '0;
      last_pin_r  <= 1'b0;
      latched_r   <= 1'b0;
      peek_r      <= 1'b0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_acc) begin
            last_sent_r <= sent_u;
            last_det_r  <= det_u;
            last_rise_r <= rise_u;
            pending_r   <= pending_u;
            last_evt_r  <= evt_u;
            last_pin_r  <= pin_u;
            latched_r   <= latched_u;
            if (is_poll) begin
              state_r <= F_ACCT;
            end
          end
        end
        F_ACCT: begin
          pending_r <= '0;
          peek_r    <= peek_mid || inc;
          state_r   <= F_PUSH;
        end
        F_PUSH: begin
          if (job_ready) begin
            if (cnt_nz) begin
              total_r <= total_sum;
              mode_r  <= M_RUNNING;
              lpe_r   <= det_r;
            end else if (timeout_hit) begin
              mode_r <= M_TIMED_OUT;
            end
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  // payload registers of the poll in flight
  always_ff @(posedge clk) begin
    if (in_acc && is_poll) begin
      poll_now_r <= in_data.now_us;
    end
    if (state_r == F_ACCT) begin
      cnt_r <= cnt_a;
      det_r <= inc ? last_rise_r : last_det_r;
    end
  end

endmodule

@@ hw/rtl/pmfp_queue.sv @@
// Short FIFO of division jobs between the front end and the divider.
// Register based, depth from pmfp_pkg.
module pmfp_queue
  import pmfp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);

  job_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push, pop;

  assign push_ready = (count_r != FULL);
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/pmfp_back.sv @@
// Back end: serial restoring divider for the mean period, clamp, and the
// output register toward the result channel. Uses pmfp_pkg.
module pmfp_back
  import pmfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_ready,
  input  job_t              job,
  input  logic [DATA_W-1:0] max_period,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data
);

  localparam int BIT_W = $clog2(DATA_W);

  typedef enum logic [1:0] {B_IDLE, B_DIV, B_FIN} bstate_t;

  bstate_t           state_r;
  logic [BIT_W-1:0]  bit_r;
  logic [DATA_W-1:0] rem_r, quo_r;
  job_t              job_r;
  logic              out_valid_r;
  out_item_t         out_r;

  logic [DATA_W:0]   trial, diff;
  logic              fits;
  logic [DATA_W-1:0] period;
  logic              fin_go;

  assign job_ready = (state_r == B_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign fin_go    = (state_r == B_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    trial = {rem_r, quo_r[DATA_W-1]};
    diff  = trial - {1'b0, job_r.cnt};
    fits  = (trial >= {1'b0, job_r.cnt});
  end

  always_comb begin
    if (job_r.cnt == '0) begin
      period = '0;
    end else if (quo_r == '0) begin
      period = DATA_W'(1);
    end else if ((max_period != '0) && (quo_r > max_period)) begin
      period = max_period;
    end else begin
      period = quo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (job_valid) begin
            job_r   <= job;
            quo_r   <= job.num;
            rem_r   <= '0;
            bit_r   <= BIT_W'(DATA_W - 1);
            state_r <= (job.cnt == '0) ? B_FIN : B_DIV;
          end
        end
        B_DIV: begin
          // one quotient bit per cycle, MSB first
          quo_r <= {quo_r[DATA_W-2:0], fits};
          rem_r <= fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
          bit_r <= bit_r - 1'b1;
          if (bit_r == '0) begin
            state_r <= B_FIN;
          end
        end
        B_FIN: begin
          // hold the result until the output register frees up
          if (fin_go) begin
            out_r.pulse_count  <= job_r.cnt;
            out_r.period_us    <= period;
            out_r.flow_valid   <= job_r.flow_valid;
            out_r.flow_zero    <= job_r.flow_zero;
            out_r.total_pulses <= job_r.total;
            state_r            <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/pulse_meter_filter_period.sv @@
// Deglitched pulse counter and period meter, top level.
// Holds the configuration registers and ties front end, queue and divider.
// Depends on pmfp_pkg, pmfp_front, pmfp_queue and pmfp_back.
//
// Usage:
//   in_*  : pin change events (opcode 0) and polls (opcode 1), each with the
//           sampled pin level and a microsecond timestamp. An event gives no
//           result; each poll gives exactly one result on out_*.
//   cfg_* : register writes (filter_mode, filter_time, timeout_time,
//           max_period at indexes 0..3), always ready; write only while idle.
//   Throughput: one event per cycle while no poll is in flight. A poll holds
//   the input through the front-end accounting and the push to the queue;
//   then the serial divider loads the job, forms 32 quotient bits at one bit
//   per cycle and clamps the result.
//   Up to two polls queue between front end and divider, so events keep
//   flowing while a division runs; when the receiver stalls, results wait in
//   the output register and the queue, and then the input stalls.
//   Reset: synchronous, active low; all counters and timestamps clear, the
//   pin is taken as low and the configuration returns to its defaults.
module pulse_meter_filter_period
  import pmfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  cfg_t cfg_r;
  logic fq_valid, fq_ready, qb_valid, qb_ready;
  job_t fq_job, qb_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.filter_mode  <= FILTER_SPACING;
      cfg_r.filter_time  <= RST_FILTER_TIME;
      cfg_r.timeout_time <= RST_TIMEOUT_TIME;
      cfg_r.max_period   <= RST_MAX_PERIOD;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FILTER_MODE:  cfg_r.filter_mode  <= cfg_data[0];
        CFG_FILTER_TIME:  cfg_r.filter_time  <= cfg_data;
        CFG_TIMEOUT_TIME: cfg_r.timeout_time <= cfg_data;
        CFG_MAX_PERIOD:   cfg_r.max_period   <= cfg_data;
        default: ;
      endcase
    end
  end

  pmfp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job       (fq_job)
  );

  pmfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_job)
  );

  pmfp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (qb_valid),
    .job_ready  (qb_ready),
    .job        (qb_job),
    .max_period (cfg_r.max_period),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // a poll with no pulses reports no period and cannot be a valid measurement
  a_no_count_no_period: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.pulse_count == '0) |->
      (out_data.period_us == '0) && !out_data.flow_valid)
    else $error("period or flow_valid set without pulses");

  // a counted poll never reports a zero period and never declares a timeout
  a_count_has_period: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.pulse_count != '0) |->
      (out_data.period_us != '0) && !out_data.flow_zero)
    else $error("counted poll with zero period or timeout");

  // the clamp keeps the period at or below a nonzero maximum
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (cfg_r.max_period != '0) |-> (out_data.period_us <= cfg_r.max_period))
    else $error("period above max_period");

endmodule
